[src/edg_pkg.sv]
// Package for the entropy dual objective and gradient block.
// Holds the item structs, the sequencer state type and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package edg_pkg;

  // Width of the log argument s = t - alpha - x, signed.
  localparam int S_W = 35;
  // Operand width of the shared multiplier, signed.
  localparam int MUL_W = 37;
  localparam int PROD_W = 2 * MUL_W;
  // Width of the log2 magnitude and of the ln magnitude.
  localparam int MAG_W = 36;
  // ln(2) in Q0.28, rounded.
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  localparam logic [1:0] CFG_COST_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_NORM_SQUARED = 2'd1;
  localparam logic [1:0] CFG_TRUE_CLASS = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_value;
    logic signed [31:0] alpha_offset;
    logic signed [31:0] linear_coeff;
    logic               last_element;
  } edg_in_t;

  typedef struct packed {
    logic signed [31:0] gradient;
    logic signed [47:0] objective_sum;
    logic               objective_valid;
    logic               domain_error;
    logic               any_domain_error;
  } edg_out_t;

  // One classified element, passed from the front end to the back end.
  typedef struct packed {
    logic signed [31:0]    x;
    logic signed [31:0]    q;
    logic signed [S_W-1:0] s;
    logic                  derr;
    logic                  last;
  } edg_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CN,
    ST_CNX,
    ST_CQ,
    ST_QUAD,
    ST_LIN,
    ST_NORM,
    ST_SQ,
    ST_LN,
    ST_SLN,
    ST_FIN
  } edg_state_t;

endpackage

[src/edg_front.sv]
// Front end: accepts input items, tracks the element position and forms s.
// Depends on edg_pkg.
`timescale 1ns / 1ps

module edg_front #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  edg_pkg::edg_in_t in_data,
  input  logic [9:0]       true_class_index,
  input  logic             queue_full,
  output logic             push,
  output edg_pkg::edg_job_t job
);
  import edg_pkg::*;

  localparam int PW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [PW-1:0] position;
  logic [PW-1:0] position_next;
  logic signed [S_W-1:0] t_val;

  assign in_ready = !queue_full;
  assign push = in_valid && !queue_full;

  always_comb begin
    t_val = (32'(position) == 32'(true_class_index)) ? (S_W'(1) <<< FRAC_BITS) : '0;
    job.x = in_data.point_value;
    job.q = in_data.linear_coeff;
    job.s = t_val - S_W'(in_data.alpha_offset) - S_W'(in_data.point_value);
    job.derr = (job.s <= 0);
    job.last = in_data.last_element;
  end

  always_comb begin
    if (in_data.last_element) begin
      position_next = '0;
    end else if (32'(position) == MAX_ELEMENTS - 1) begin
      position_next = '0;
    end else begin
      position_next = position + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      position <= position_next;
    end
  end

endmodule

[src/edg_queue.sv]
// Two-entry queue of classified elements between front and back end.
// Depends on edg_pkg.
`timescale 1ns / 1ps

module edg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  edg_pkg::edg_job_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output edg_pkg::edg_job_t head
);
  import edg_pkg::*;

  edg_job_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[src/edg_back.sv]
// Back end: sequencer around one shared multiplier that forms the gradient,
// the log and the objective terms, plus the accumulator and output register.
// Depends on edg_pkg.
`timescale 1ns / 1ps

module edg_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  edg_pkg::edg_job_t job,
  output logic              pop,
  input  logic [30:0]       cost_weight,
  input  logic [30:0]       norm_squared,
  output logic              out_valid,
  input  logic              out_ready,
  output edg_pkg::edg_out_t out_data
);
  import edg_pkg::*;

  localparam int KW = $clog2(FRAC_BITS + 1);
  localparam logic signed [PROD_W-1:0] P32_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] P32_MIN = -PROD_W'(64'sd2147483648);
  localparam logic signed [65:0] W32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] W32_MIN = -66'sd2147483648;
  localparam logic signed [65:0] ACC_MAX = 66'sd140737488355327;
  localparam logic signed [65:0] ACC_MIN = -66'sd140737488355328;

  edg_state_t state;
  edg_state_t state_next;

  logic signed [31:0]    cn;
  logic signed [31:0]    cnx;
  logic signed [31:0]    cq;
  logic signed [65:0]    quad;
  logic signed [65:0]    lin;
  logic signed [65:0]    sln;
  logic signed [37:0]    ln_s;
  logic [33:0]           nreg;
  logic [5:0]            lead;
  logic [31:0]           m;
  logic [FRAC_BITS-1:0]  frac;
  logic [KW-1:0]         kc;
  logic                  neg;
  logic [MAG_W-1:0]      lnmag;
  logic signed [47:0]    acc;
  logic                  sticky;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PROD_W-1:0] prod_sh1;
  logic [32:0]              sq;
  logic signed [7:0]        pdiff;
  logic signed [39:0]       l2;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        ln_round;
  logic [PROD_W-1:0]        pm;
  logic                     pm_frac;
  logic signed [65:0]       grad_sum;
  logic signed [65:0]       contrib;
  logic signed [65:0]       contrib_sat;
  logic signed [65:0]       acc_sum;
  logic signed [47:0]       acc_new;
  logic                     slot_free;
  logic                     out_load;

  function automatic logic signed [31:0] sat_prod(input logic signed [PROD_W-1:0] v);
    if (v > P32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < P32_MIN) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_CN: begin
        mul_a = MUL_W'(cost_weight);
        mul_b = MUL_W'(norm_squared);
      end
      ST_CNX: begin
        mul_a = MUL_W'(cn);
        mul_b = MUL_W'(job.x);
      end
      ST_CQ: begin
        mul_a = MUL_W'(cost_weight);
        mul_b = MUL_W'(job.q);
      end
      ST_QUAD: begin
        mul_a = MUL_W'(cnx);
        mul_b = MUL_W'(job.x);
      end
      ST_LIN: begin
        mul_a = MUL_W'(cq);
        mul_b = MUL_W'(job.x);
      end
      ST_SQ: begin
        mul_a = MUL_W'(m);
        mul_b = MUL_W'(m);
      end
      ST_LN: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(LN2_Q28);
      end
      ST_SLN: begin
        mul_a = MUL_W'(job.s);
        mul_b = MUL_W'(lnmag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod = mul_a * mul_b;
    prod_sh = prod >>> FRAC_BITS;
    prod_sh1 = prod >>> (FRAC_BITS + 1);
    sq = prod[63:31];
    pdiff = 8'(lead) - 8'(FRAC_BITS);
    l2 = (40'(pdiff) <<< FRAC_BITS) + 40'(frac);
    mag = l2[39] ? MAG_W'(-l2) : MAG_W'(l2);
    ln_round = (prod + PROD_W'(1 << 27)) >> 28;
    pm = prod >> FRAC_BITS;
    pm_frac = (prod[FRAC_BITS-1:0] != '0);
  end

  // Final combine of one element.
  always_comb begin
    grad_sum = 66'(cnx) + 66'(cq) + (66'sd1 <<< FRAC_BITS) - 66'(ln_s);
    contrib = sln + quad + lin;
    if (contrib > ACC_MAX) begin
      contrib_sat = ACC_MAX;
    end else if (contrib < ACC_MIN) begin
      contrib_sat = ACC_MIN;
    end else begin
      contrib_sat = contrib;
    end
    acc_sum = 66'(acc) + contrib_sat;
    if (acc_sum > ACC_MAX) begin
      acc_new = 48'(ACC_MAX);
    end else if (acc_sum < ACC_MIN) begin
      acc_new = 48'(ACC_MIN);
    end else begin
      acc_new = 48'(acc_sum);
    end
  end

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: state_next = job_valid ? ST_CN : ST_IDLE;
      ST_CN: state_next = ST_CNX;
      ST_CNX: state_next = ST_CQ;
      ST_CQ: state_next = ST_QUAD;
      ST_QUAD: state_next = ST_LIN;
      ST_LIN: state_next = job.derr ? ST_FIN : ST_NORM;
      ST_NORM: state_next = nreg[33] ? ST_SQ : ST_NORM;
      ST_SQ: state_next = (32'(kc) == FRAC_BITS - 1) ? ST_LN : ST_SQ;
      ST_LN: state_next = ST_SLN;
      ST_SLN: state_next = ST_FIN;
      ST_FIN: state_next = slot_free ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load = (state == ST_FIN) && slot_free;
    pop = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CN: begin
        cn <= (prod_sh > P32_MAX) ? 32'sh7FFFFFFF : 32'(prod_sh);
        sln <= '0;
        ln_s <= '0;
        nreg <= job.s[33:0];
        lead <= 6'd33;
      end
      ST_CNX: cnx <= sat_prod(prod_sh);
      ST_CQ: cq <= sat_prod(prod_sh);
      ST_QUAD: quad <= 66'(prod_sh1);
      ST_LIN: lin <= 66'(prod_sh);
      ST_NORM: begin
        if (nreg[33]) begin
          m <= nreg[33:2];
          kc <= '0;
        end else begin
          nreg <= {nreg[32:0], 1'b0};
          lead <= lead - 6'd1;
        end
      end
      ST_SQ: begin
        frac <= {frac[FRAC_BITS-2:0], sq[32]};
        m <= sq[32] ? sq[32:1] : sq[31:0];
        kc <= kc + KW'(1);
      end
      ST_LN: begin
        neg <= l2[39];
        lnmag <= MAG_W'(ln_round);
        ln_s <= l2[39] ? -38'(MAG_W'(ln_round)) : 38'(MAG_W'(ln_round));
      end
      ST_SLN: begin
        sln <= neg ? (-66'(pm) - 66'(pm_frac)) : 66'(pm);
      end
      default: begin
      end
    endcase
  end

  // Accumulator, sticky flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sticky <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        acc <= job.last ? '0 : acc_new;
        sticky <= job.last ? 1'b0 : (sticky || job.derr);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (grad_sum > W32_MAX) begin
        out_data.gradient <= 32'sh7FFFFFFF;
      end else if (grad_sum < W32_MIN) begin
        out_data.gradient <= 32'sh80000000;
      end else begin
        out_data.gradient <= 32'(grad_sum);
      end
      out_data.objective_sum <= job.last ? acc_new : '0;
      out_data.objective_valid <= job.last;
      out_data.domain_error <= job.derr;
      out_data.any_domain_error <= sticky || job.derr;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && job.last) |=> (acc == '0 && !sticky))
    else $error("accumulator not cleared after last element");
  a_sum_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.objective_valid) |-> (out_data.objective_sum == '0))
    else $error("objective sum shown on a non-last element");
  a_sticky_covers: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.domain_error) |-> out_data.any_domain_error)
    else $error("domain error not reflected in sticky flag");
  a_mantissa_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> m[31])
    else $error("log mantissa not normalized");

endmodule

[src/entropy_dual_objective_gradient.sv]
// Top level of the entropy dual objective and gradient block.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on edg_pkg, edg_front, edg_queue and edg_back.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data  (edg_in_t)
//   out      output     out_valid / out_ready  out_data (edg_out_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The back end works on one item at a time; its time per item grows with
// FRAC_BITS and with the number of normalizing steps of the log argument;
// an item with a domain error skips the log. The serial squaring loop of the
// log2 step on the shared multiplier dominates this time.
// Reset is synchronous and clears the position counter, the accumulator, the
// sticky flag, the queue and the output register; configuration returns to
// C = 1.0, norm = 1.0, true class 0.
// The two-entry queue lets the front end take one more item while the back end
// works or waits for the output to be taken.
`timescale 1ns / 1ps

module entropy_dual_objective_gradient #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  edg_pkg::edg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output edg_pkg::edg_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import edg_pkg::*;

  logic [30:0] cost_weight;
  logic [30:0] norm_squared;
  logic [9:0]  true_class_index;

  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_empty;
  edg_job_t front_job;
  edg_job_t head_job;

  // cfg_ready tied high, so the user keeps writes to when the block idles.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_weight <= 31'(1) << FRAC_BITS;
      norm_squared <= 31'(1) << FRAC_BITS;
      true_class_index <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COST_WEIGHT: cost_weight <= cfg_data[30:0];
        CFG_NORM_SQUARED: norm_squared <= cfg_data[30:0];
        CFG_TRUE_CLASS: true_class_index <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each element and forms its log argument.
  edg_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .true_class_index(true_class_index),
    .queue_full(queue_full),
    .push(push),
    .job(front_job)
  );

  edg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(front_job),
    .pop(pop),
    .full(queue_full),
    .empty(queue_empty),
    .head(head_job)
  );

  // The back end does the arithmetic and owns the running objective sum.
  edg_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(!queue_empty),
    .job(head_job),
    .pop(pop),
    .cost_weight(cost_weight),
    .norm_squared(norm_squared),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
